// ===== src/dcp_pkg.sv =====
// shared types and constants for the dcp identify response filter
package dcp_pkg;

    localparam int MaxDevices = 16;
    localparam int NameCap    = 32;
    localparam int MaxFrame   = 1500;

    localparam logic [15:0] FRAME_ID_IDENT = 16'hFEFD;
    localparam logic [7:0]  SVC_IDENTIFY   = 8'h05;
    localparam logic [7:0]  SVC_TYPE_OK    = 8'h01;
    localparam logic [7:0]  OPT_IP         = 8'h01;
    localparam logic [7:0]  SUB_IP_PARAM   = 8'h02;
    localparam logic [7:0]  OPT_DEVPROP    = 8'h02;
    localparam logic [7:0]  SUB_NAME       = 8'h02;
    localparam logic [7:0]  SUB_DEVID      = 8'h03;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_SHORT     = 3'd1;
    localparam logic [2:0] ST_FRAME_ID  = 3'd2;
    localparam logic [2:0] ST_SERVICE   = 3'd3;
    localparam logic [2:0] ST_XID       = 3'd4;
    localparam logic [2:0] ST_DUPLICATE = 3'd5;
    localparam logic [2:0] ST_FULL      = 3'd6;

    localparam logic CFG_EXPECTED_XID = 1'b0;
    localparam logic CFG_DEVICE_LIMIT = 1'b1;

    typedef enum logic [4:0] {
        PH_IDLE   = 5'b00001,
        PH_HEADER = 5'b00010,
        PH_BODY   = 5'b00100,
        PH_PAD    = 5'b01000,
        PH_DONE   = 5'b10000
    } t_phase;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [47:0] source_mac;
        logic        first_byte;
        logic        last_byte;
    } t_in_beat;

    typedef struct packed {
        logic        kind;
        logic [2:0]  status;
        logic [47:0] mac_addr;
        logic [15:0] vendor_ident;
        logic [15:0] device_ident;
        logic [31:0] ip_addr;
        logic        ip_present;
        logic [4:0]  name_length;
        logic [4:0]  name_index;
        logic [7:0]  name_char;
        logic [4:0]  device_count;
        logic        end_of_run;
    } t_out_beat;

    // frame summary handed from parser to emitter
    typedef struct packed {
        logic [2:0]  status;
        logic [47:0] mac;
        logic [31:0] ids;
        logic [32:0] ip;
        logic [4:0]  name_len;
        logic [4:0]  count;
    } t_frame_sum;

endpackage

// ===== src/dcp_front.sv =====
// byte parser, header checks, option walk and device table
module dcp_front #(
    parameter int MAX_DEVICES = dcp_pkg::MaxDevices,
    parameter int NAME_CAP    = dcp_pkg::NameCap,
    parameter int MAX_FRAME   = dcp_pkg::MaxFrame
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  dcp_pkg::t_in_beat     i_beat,
    input  logic                  i_take,
    input  logic                  i_cfg_wr,
    input  logic                  i_cfg_idx,
    input  logic [31:0]           i_cfg_data,
    output logic                  o_sum_valid,
    output dcp_pkg::t_frame_sum   o_sum,
    output logic [7:0]            o_name [NAME_CAP-1]
);
    localparam int PW = 11;
    localparam int DW = $clog2(MAX_DEVICES + 1);
    localparam int IW = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
    localparam int NW = $clog2(NAME_CAP);
    localparam logic [NW-1:0] NLIM = NW'(NAME_CAP - 1);

    logic [31:0] r_xid_exp;
    logic [4:0]  r_limit;
    logic [PW-1:0] r_pos, n_pos;
    logic [2:0]  r_fst, n_fst;
    logic [47:0] r_mac, n_mac;
    logic [31:0] r_xsh, n_xsh;
    logic [16:0] r_dend, n_dend;
    logic [31:0] r_hdr, n_hdr;
    logic [15:0] r_boff, n_boff;
    dcp_pkg::t_phase r_ph, n_ph;
    logic [31:0] r_fsh, n_fsh;
    logic [7:0]  r_nw [NAME_CAP-1];
    logic [7:0]  r_nk [NAME_CAP-1];
    logic [NW-1:0] r_nwl, n_nwl, r_nkl, n_nkl;
    logic [31:0] r_ids, n_ids;
    logic [32:0] r_ip, n_ip;
    logic [47:0] r_tab [MAX_DEVICES];
    logic [DW-1:0] r_cnt;
    logic        w_nw_we, w_copy;

    logic [7:0]  b;
    logic        w_new;
    logic [PW-1:0] p;
    logic        w_hit;
    logic [DW-1:0] w_lim;
    logic [2:0]  w_stat;
    logic [16:0] w_end_chk;
    logic [15:0] w_blen;
    logic [31:0] w_hdr_sh;

    assign b = i_beat.data_byte;
    assign w_new = i_beat.first_byte || (r_pos == '0);

    always_comb begin
        p      = w_new ? '0 : r_pos;
        n_pos  = p;
        n_fst  = w_new ? ST_OK_F() : r_fst;
        n_mac  = w_new ? i_beat.source_mac : r_mac;
        n_xsh  = w_new ? '0 : r_xsh;
        n_dend = w_new ? '0 : r_dend;
        n_hdr  = w_new ? '0 : r_hdr;
        n_boff = w_new ? '0 : r_boff;
        n_ph   = w_new ? dcp_pkg::PH_IDLE : r_ph;
        n_fsh  = w_new ? '0 : r_fsh;
        n_nwl  = w_new ? '0 : r_nwl;
        n_nkl  = w_new ? '0 : r_nkl;
        n_ids  = w_new ? '0 : r_ids;
        n_ip   = w_new ? '0 : r_ip;
        w_nw_we = 1'b0;
        w_copy  = 1'b0;
        w_blen  = n_hdr[15:0];
        w_hdr_sh = {n_hdr[23:0], b};
        w_end_chk = 17'(p) + 17'd1 + 17'(w_hdr_sh[15:0]);
        if (32'(p) < 32'(MAX_FRAME)) begin
            n_pos = p + 1'b1;
            if (p < PW'(8)) begin
                n_xsh = {n_xsh[23:0], b};
                if (p == PW'(3)) begin
                    if (n_fst == '0) begin
                        if (n_xsh[31:16] != dcp_pkg::FRAME_ID_IDENT)
                            n_fst = dcp_pkg::ST_FRAME_ID;
                        else if (n_xsh[15:8] != dcp_pkg::SVC_IDENTIFY
                                 || n_xsh[7:0] != dcp_pkg::SVC_TYPE_OK)
                            n_fst = dcp_pkg::ST_SERVICE;
                    end
                end else if (p == PW'(7) && n_xsh != r_xid_exp && n_fst == '0) begin
                    n_fst = dcp_pkg::ST_XID;
                end
            end else if (p < PW'(10)) begin
                n_pos = p + 1'b1;
            end else if (p == PW'(10)) begin
                n_hdr = {24'd0, b};
            end else if (p == PW'(11)) begin
                n_dend = 17'd12 + {1'b0, n_hdr[7:0], b};
                n_hdr  = '0;
                n_boff = '0;
                n_ph   = dcp_pkg::PH_HEADER;
            end else if (n_ph == dcp_pkg::PH_IDLE || n_ph == dcp_pkg::PH_DONE) begin
                n_ph = n_ph;
            end else if (17'(p) >= n_dend) begin
                n_ph = dcp_pkg::PH_DONE;
            end else begin
                case (n_ph)
                    dcp_pkg::PH_HEADER: begin
                        n_hdr = w_hdr_sh;
                        if (n_boff < 16'd3) begin
                            n_boff = n_boff + 16'd1;
                        end else begin
                            n_boff = '0;
                            if (w_end_chk > n_dend) begin
                                n_ph = dcp_pkg::PH_DONE;
                            end else if (w_hdr_sh[15:0] == '0) begin
                                n_hdr = '0;
                            end else begin
                                n_ph  = dcp_pkg::PH_BODY;
                                n_fsh = '0;
                                n_nwl = '0;
                            end
                        end
                    end
                    dcp_pkg::PH_BODY: begin
                        if (n_boff >= 16'd2) begin
                            if (n_hdr[31:24] == dcp_pkg::OPT_DEVPROP
                                && n_hdr[23:16] == dcp_pkg::SUB_NAME && n_nwl < NLIM) begin
                                w_nw_we = 1'b1;
                                n_nwl = n_nwl + 1'b1;
                            end
                            if (n_boff < 16'd6) n_fsh = {n_fsh[23:0], b};
                        end
                        n_boff = n_boff + 16'd1;
                        if (n_boff >= w_blen) begin
                            if (w_blen >= 16'd2) begin
                                if (n_hdr[31:24] == dcp_pkg::OPT_DEVPROP
                                    && n_hdr[23:16] == dcp_pkg::SUB_NAME) begin
                                    w_copy = 1'b1;
                                    n_nkl  = n_nwl;
                                end else if (n_hdr[31:24] == dcp_pkg::OPT_DEVPROP
                                    && n_hdr[23:16] == dcp_pkg::SUB_DEVID
                                    && w_blen >= 16'd6) begin
                                    n_ids = n_fsh;
                                end else if (n_hdr[31:24] == dcp_pkg::OPT_IP
                                    && n_hdr[23:16] == dcp_pkg::SUB_IP_PARAM
                                    && w_blen >= 16'd6) begin
                                    n_ip = {1'b1, n_fsh};
                                end
                            end
                            n_ph   = w_blen[0] ? dcp_pkg::PH_PAD : dcp_pkg::PH_HEADER;
                            n_boff = '0;
                            n_hdr  = '0;
                        end
                    end
                    default: begin
                        n_ph   = dcp_pkg::PH_HEADER;
                        n_boff = '0;
                        n_hdr  = '0;
                    end
                endcase
            end
        end
    end

    function automatic logic [2:0] ST_OK_F();
        return dcp_pkg::ST_OK;
    endfunction

    // duplicate search over the table in parallel
    always_comb begin
        w_hit = 1'b0;
        for (int i = 0; i < MAX_DEVICES; i++)
            if (DW'(i) < r_cnt && r_tab[i] == n_mac) w_hit = 1'b1;
        w_lim = (32'(r_limit) < 32'(MAX_DEVICES)) ? DW'(r_limit) : DW'(MAX_DEVICES);
        if (n_pos < PW'(10))        w_stat = dcp_pkg::ST_SHORT;
        else if (n_fst != '0)       w_stat = n_fst;
        else if (w_hit)             w_stat = dcp_pkg::ST_DUPLICATE;
        else if (r_cnt >= w_lim)    w_stat = dcp_pkg::ST_FULL;
        else                        w_stat = dcp_pkg::ST_OK;
    end

    logic w_fin;
    assign w_fin = i_valid && i_take && i_beat.last_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xid_exp <= 32'd1;
            r_limit   <= 5'd16;
            r_cnt     <= '0;
            r_pos <= '0; r_fst <= '0; r_mac <= '0; r_xsh <= '0; r_dend <= '0;
            r_hdr <= '0; r_boff <= '0; r_ph <= dcp_pkg::PH_IDLE; r_fsh <= '0;
            r_nwl <= '0; r_nkl <= '0; r_ids <= '0; r_ip <= '0;
            o_sum_valid <= 1'b0;
        end else begin
            o_sum_valid <= w_fin;
            if (i_cfg_wr) begin
                if (i_cfg_idx == dcp_pkg::CFG_EXPECTED_XID) begin
                    r_xid_exp <= i_cfg_data;
                    r_cnt     <= '0;
                end else begin
                    r_limit <= i_cfg_data[4:0];
                end
            end
            if (i_valid && i_take) begin
                if (i_beat.last_byte) begin
                    r_pos <= '0; r_fst <= '0; r_mac <= '0; r_xsh <= '0; r_dend <= '0;
                    r_hdr <= '0; r_boff <= '0; r_ph <= dcp_pkg::PH_IDLE; r_fsh <= '0;
                    r_nwl <= '0; r_nkl <= '0; r_ids <= '0; r_ip <= '0;
                    if (w_stat == dcp_pkg::ST_OK) r_cnt <= r_cnt + 1'b1;
                end else begin
                    r_pos <= n_pos; r_fst <= n_fst; r_mac <= n_mac; r_xsh <= n_xsh;
                    r_dend <= n_dend; r_hdr <= n_hdr; r_boff <= n_boff; r_ph <= n_ph;
                    r_fsh <= n_fsh; r_nwl <= n_nwl; r_nkl <= n_nkl; r_ids <= n_ids;
                    r_ip <= n_ip;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && i_take) begin
            if (w_nw_we) r_nw[r_nwl_eff()] <= b;
            if (w_fin && w_stat == dcp_pkg::ST_OK)
                r_tab[IW'(r_cnt)] <= n_mac;
            if (w_fin) begin
                o_sum.status   <= w_stat;
                o_sum.mac      <= n_mac;
                o_sum.ids      <= n_ids;
                o_sum.ip       <= n_ip;
                o_sum.name_len <= 5'(n_nkl);
                o_sum.count    <= 5'(r_cnt + DW'(w_stat == dcp_pkg::ST_OK));
            end
        end
    end

    // name copy; the final name also lands in the output copy at frame end
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NAME_CAP - 1; i++) begin
            if (i_valid && i_take) begin
                if (w_copy) begin
                    r_nk[i] <= (w_nw_we && NW'(i) == r_nwl_eff()) ? b : r_nw[i];
                end
            end
            if (w_fin) begin
                if (w_copy)
                    o_name[i] <= (w_nw_we && NW'(i) == r_nwl_eff()) ? b : r_nw[i];
                else
                    o_name[i] <= r_nk[i];
            end
        end
    end

    function automatic logic [NW-1:0] r_nwl_eff();
        return n_nwl - 1'b1;
    endfunction

endmodule

// ===== src/dcp_back.sv =====
// frame record and name byte emitter with output register
module dcp_back #(
    parameter int NAME_CAP = dcp_pkg::NameCap
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_sum_valid,
    input  dcp_pkg::t_frame_sum i_sum,
    input  logic [7:0]          i_name [NAME_CAP-1],
    output logic                o_busy,
    output logic                o_valid,
    input  logic                i_stall,
    output dcp_pkg::t_out_beat  o_beat
);
    localparam int NW = $clog2(NAME_CAP);

    dcp_pkg::t_frame_sum r_sum;
    logic [7:0] r_name [NAME_CAP-1];
    logic       r_act;
    logic [5:0] r_k;
    logic [5:0] w_n;
    logic       w_ok;
    dcp_pkg::t_out_beat w_b;

    assign w_ok = (r_sum.status == dcp_pkg::ST_OK);
    assign w_n  = w_ok ? 6'(r_sum.name_len) + 6'd1 : 6'd1;
    assign o_busy = r_act;

    always_comb begin
        w_b.kind         = (r_k != '0);
        w_b.status       = r_sum.status;
        w_b.mac_addr     = r_sum.mac;
        w_b.vendor_ident = w_ok ? r_sum.ids[31:16] : '0;
        w_b.device_ident = w_ok ? r_sum.ids[15:0] : '0;
        w_b.ip_addr      = w_ok ? r_sum.ip[31:0] : '0;
        w_b.ip_present   = w_ok & r_sum.ip[32];
        w_b.name_length  = w_ok ? r_sum.name_len : '0;
        w_b.name_index   = (r_k == '0) ? '0 : 5'(r_k - 6'd1);
        w_b.name_char    = (r_k == '0) ? '0 : r_name[NW'(r_k - 6'd1)];
        w_b.device_count = r_sum.count;
        w_b.end_of_run   = (r_k + 6'd1 == w_n);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act   <= 1'b0;
            r_k     <= '0;
            o_valid <= 1'b0;
        end else begin
            if (o_valid && !i_stall) o_valid <= 1'b0;
            if (i_sum_valid) begin
                r_act <= 1'b1;
                r_k   <= '0;
            end else if (r_act && (!o_valid || !i_stall)) begin
                o_valid <= 1'b1;
                r_k     <= r_k + 6'd1;
                if (r_k + 6'd1 == w_n) r_act <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_sum_valid) begin
            r_sum <= i_sum;
            for (int i = 0; i < NAME_CAP - 1; i++) r_name[i] <= i_name[i];
        end
        if (!i_sum_valid && r_act && (!o_valid || !i_stall)) o_beat <= w_b;
    end

endmodule

// ===== src/dcp_identify_response_filter_core.sv =====
// top level of the dcp identify response filter
// record path: parser summary register, emitter, output register
// throughput: one byte per cycle within a frame; the last byte of a frame is
// taken only once the emitter has finished the previous frame's results
// (1 + name length beats, or 1 if rejected), set by the single result emitter
// reset: synchronous active low; table emptied, xid 1, device limit 16
module dcp_identify_response_filter_core #(
    parameter int MAX_DEVICES = dcp_pkg::MaxDevices,
    parameter int NAME_CAP    = dcp_pkg::NameCap,
    parameter int MAX_FRAME   = dcp_pkg::MaxFrame
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  dcp_pkg::t_in_beat  i_beat,
    output logic               o_valid,
    input  logic               i_stall,
    output dcp_pkg::t_out_beat o_beat,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
    logic                w_sum_valid;
    dcp_pkg::t_frame_sum w_sum;
    logic [7:0]          w_name [NAME_CAP-1];
    logic                w_busy;

    // only frame-ending beats wait for the emitter (summary slot in use)
    assign o_stall     = i_beat.last_byte && (w_busy || w_sum_valid);
    assign o_cfg_ready = 1'b1;

    dcp_front #(
        .MAX_DEVICES(MAX_DEVICES), .NAME_CAP(NAME_CAP), .MAX_FRAME(MAX_FRAME)
    ) u_front (
        .i_clk, .i_rst_n, .i_valid, .i_beat,
        .i_take(!o_stall),
        .i_cfg_wr(i_cfg_valid), .i_cfg_idx(i_cfg_index), .i_cfg_data,
        .o_sum_valid(w_sum_valid), .o_sum(w_sum), .o_name(w_name)
    );

    dcp_back #(.NAME_CAP(NAME_CAP)) u_back (
        .i_clk, .i_rst_n,
        .i_sum_valid(w_sum_valid), .i_sum(w_sum), .i_name(w_name),
        .o_busy(w_busy), .o_valid, .i_stall, .o_beat
    );

endmodule

// ===== src/dcp_checker.sv =====
// port-level checks for the filter, bound to the top level
module dcp_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_stall,
    input dcp_pkg::t_out_beat o_beat
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_beat)) else $error("stall hold");
    a_rec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_beat.kind |-> o_beat.name_index == '0 && o_beat.name_char == '0)
        else $error("record fields");
    a_rej: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_beat.status != dcp_pkg::ST_OK |-> o_beat.end_of_run && !o_beat.kind)
        else $error("reject run");
    a_name: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_beat.kind |-> o_beat.name_index < o_beat.name_length)
        else $error("name index");
endmodule

bind dcp_identify_response_filter_core dcp_checker u_chk (
    .i_clk, .i_rst_n, .o_valid, .i_stall, .o_beat
);

// ===== test/tb_dcp_identify_response_filter_core.sv =====
// testbench for the dcp identify response filter: frame stimulus, scoreboard and checks
`timescale 1ns / 1ps

module tb_dcp_identify_response_filter_core;
    import dcp_pkg::*;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_stall;
    t_in_beat  i_beat = '0;
    logic      o_valid;
    logic      i_stall = 1'b0;
    t_out_beat o_beat;
    logic      i_cfg_valid = 1'b0;
    logic      o_cfg_ready;
    logic      i_cfg_index = 1'b0;
    logic [31:0] i_cfg_data = '0;

    dcp_identify_response_filter_core uut (.*);

    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // predictor state
    // ------------------------------------------------------------------
    localparam int NameMax = NameCap - 1;

    logic [31:0] xid_reg;
    logic [4:0]  limit_reg;
    int          pos;
    logic [2:0]  fstat;
    logic [47:0] fmac;
    logic [31:0] hdr_shift;
    int          data_end;
    logic [31:0] blk_hdr;
    int          blk_off;
    t_phase      phase;
    logic [31:0] fld;
    logic [7:0]  nwork [NameCap];
    logic [7:0]  nkept [NameCap];
    int          nwork_len, nkept_len;
    logic [31:0] ids_kept;
    logic [32:0] ip_kept;
    logic [47:0] seen_macs [MaxDevices];
    int          seen_count;

    t_in_beat  pending_bytes [$];
    t_out_beat expected_beats [$];
    int        errors = 0;
    int        frames_sent = 0, beats_checked = 0, accepted_frames = 0;

    // idling percentages and long hold-off control
    int  send_idle_pct = 0, recv_idle_pct = 0;
    bit  hold_recv = 0;

    function automatic void clear_frame();
        pos = 0; fstat = ST_OK; fmac = '0; hdr_shift = '0; data_end = 0;
        blk_hdr = '0; blk_off = 0; phase = PH_IDLE; fld = '0;
        nwork_len = 0; nkept_len = 0; ids_kept = '0; ip_kept = '0;
    endfunction

    function automatic void fault(logic [2:0] code);
        if (fstat == ST_OK) fstat = code;
    endfunction

    // commit a block only once all of its bytes have arrived
    function automatic void commit_block();
        logic [7:0]  opt, sub;
        logic [15:0] blen;
        opt = blk_hdr[31:24]; sub = blk_hdr[23:16]; blen = blk_hdr[15:0];
        if (blen < 2) return;
        if (opt == OPT_DEVPROP && sub == SUB_NAME) begin
            nkept = nwork;
            nkept_len = nwork_len;
        end else if (opt == OPT_DEVPROP && sub == SUB_DEVID && blen >= 6) begin
            ids_kept = fld;
        end else if (opt == OPT_IP && sub == SUB_IP_PARAM && blen >= 6) begin
            ip_kept = {1'b1, fld};
        end
    endfunction

    function automatic void parse_byte(logic [7:0] b);
        int p;
        int blen;
        p = pos;
        if (p >= MaxFrame) return;
        pos = p + 1;
        if (p < 8) begin
            hdr_shift = {hdr_shift[23:0], b};
            if (p == 3) begin
                if (hdr_shift[31:16] != FRAME_ID_IDENT) fault(ST_FRAME_ID);
                else if (hdr_shift[15:8] != SVC_IDENTIFY || hdr_shift[7:0] != SVC_TYPE_OK)
                    fault(ST_SERVICE);
            end else if (p == 7 && hdr_shift != xid_reg) begin
                fault(ST_XID);
            end
            return;
        end
        if (p < 10) return;
        if (p == 10) begin
            blk_hdr = {24'd0, b};
            return;
        end
        if (p == 11) begin
            data_end = 12 + {blk_hdr[7:0], b};
            blk_hdr = '0; blk_off = 0; phase = PH_HEADER;
            return;
        end
        if (phase == PH_IDLE || phase == PH_DONE) return;
        if (p >= data_end) begin
            phase = PH_DONE;
            return;
        end
        case (phase)
            PH_HEADER: begin
                blk_hdr = {blk_hdr[23:0], b};
                if (blk_off < 3) begin
                    blk_off++;
                    return;
                end
                blk_off = 0;
                blen = blk_hdr[15:0];
                if (p + 1 + blen > data_end) phase = PH_DONE;
                else if (blen == 0) blk_hdr = '0;
                else begin
                    phase = PH_BODY; fld = '0; nwork_len = 0;
                end
            end
            PH_BODY: begin
                blen = blk_hdr[15:0];
                if (blk_off >= 2) begin
                    if (blk_hdr[31:24] == OPT_DEVPROP && blk_hdr[23:16] == SUB_NAME
                            && nwork_len < NameMax) begin
                        nwork[nwork_len] = b;
                        nwork_len++;
                    end
                    if (blk_off - 2 < 4) fld = {fld[23:0], b};
                end
                blk_off++;
                if (blk_off >= blen) begin
                    commit_block();
                    phase = blen[0] ? PH_PAD : PH_HEADER;
                    blk_off = 0; blk_hdr = '0;
                end
            end
            default: begin
                // pad byte after an odd-length block
                phase = PH_HEADER; blk_off = 0; blk_hdr = '0;
            end
        endcase
    endfunction

    function automatic logic [2:0] filter_frame();
        int lim;
        lim = (limit_reg < MaxDevices) ? limit_reg : MaxDevices;
        if (pos < 10) return ST_SHORT;
        if (fstat != ST_OK) return fstat;
        for (int i = 0; i < seen_count && i < MaxDevices; i++)
            if (seen_macs[i] == fmac) return ST_DUPLICATE;
        if (seen_count >= lim) return ST_FULL;
        seen_macs[seen_count % MaxDevices] = fmac;
        seen_count++;
        return ST_OK;
    endfunction

    // predict the results of one accepted byte
    function automatic void predict_beat(t_in_beat it);
        logic [2:0] st;
        int         nres;
        t_out_beat  o;
        if (it.first_byte || pos == 0) begin
            clear_frame();
            fmac = it.source_mac;
        end
        parse_byte(it.data_byte);
        if (!it.last_byte) return;
        st = filter_frame();
        nres = (st == ST_OK) ? 1 + nkept_len : 1;
        if (st == ST_OK) accepted_frames++;
        for (int k = 0; k < nres; k++) begin
            o = '0;
            o.kind = (k != 0);
            o.status = st;
            o.mac_addr = fmac;
            if (st == ST_OK) begin
                o.vendor_ident = ids_kept[31:16];
                o.device_ident = ids_kept[15:0];
                o.ip_addr = ip_kept[31:0];
                o.ip_present = ip_kept[32];
                o.name_length = nkept_len[4:0];
            end
            if (k != 0) begin
                o.name_index = k - 1;
                o.name_char = nkept[k - 1];
            end
            o.device_count = seen_count[4:0];
            o.end_of_run = (k + 1 == nres);
            expected_beats.push_back(o);
        end
        clear_frame();
    endfunction

    // ------------------------------------------------------------------
    // driver: feeds bytes from the pending queue, predicts on acceptance
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                predict_beat(i_beat);
                if (i_beat.last_byte) frames_sent++;
            end
            // a held beat keeps its payload; otherwise pick the next one
            if (!(i_valid && o_stall)) begin
                if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_beat  <= pending_bytes.pop_front();
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: compares every accepted result beat with the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out_beat e;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (expected_beats.size() == 0) begin
                    $error("unexpected result beat mac=%h", o_beat.mac_addr);
                    errors++;
                end else begin
                    e = expected_beats.pop_front();
                    beats_checked++;
                    if (o_beat.kind !== e.kind) begin
                        $error("kind exp %0d got %0d", e.kind, o_beat.kind); errors++;
                    end
                    if (o_beat.status !== e.status) begin
                        $error("status exp %0d got %0d", e.status, o_beat.status); errors++;
                    end
                    if (o_beat.mac_addr !== e.mac_addr) begin
                        $error("mac_addr exp %h got %h", e.mac_addr, o_beat.mac_addr); errors++;
                    end
                    if (o_beat.vendor_ident !== e.vendor_ident) begin
                        $error("vendor_ident exp %h got %h", e.vendor_ident,
                               o_beat.vendor_ident); errors++;
                    end
                    if (o_beat.device_ident !== e.device_ident) begin
                        $error("device_ident exp %h got %h", e.device_ident,
                               o_beat.device_ident); errors++;
                    end
                    if (o_beat.ip_addr !== e.ip_addr) begin
                        $error("ip_addr exp %h got %h", e.ip_addr, o_beat.ip_addr); errors++;
                    end
                    if (o_beat.ip_present !== e.ip_present) begin
                        $error("ip_present exp %0d got %0d", e.ip_present,
                               o_beat.ip_present); errors++;
                    end
                    if (o_beat.name_length !== e.name_length) begin
                        $error("name_length exp %0d got %0d", e.name_length,
                               o_beat.name_length); errors++;
                    end
                    if (o_beat.name_index !== e.name_index) begin
                        $error("name_index exp %0d got %0d", e.name_index,
                               o_beat.name_index); errors++;
                    end
                    if (o_beat.name_char !== e.name_char) begin
                        $error("name_char exp %h got %h", e.name_char, o_beat.name_char);
                        errors++;
                    end
                    if (o_beat.device_count !== e.device_count) begin
                        $error("device_count exp %0d got %0d", e.device_count,
                               o_beat.device_count); errors++;
                    end
                    if (o_beat.end_of_run !== e.end_of_run) begin
                        $error("end_of_run exp %0d got %0d", e.end_of_run,
                               o_beat.end_of_run); errors++;
                    end
                end
            end
            i_stall <= hold_recv || ($urandom_range(99) < recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // frame builders
    // ------------------------------------------------------------------
    logic [47:0] mac_pool [8];

    // append a block: option, suboption, length, block info, data and odd pad (length = 2 + data)
    task automatic add_block(inout logic [7:0] body[$], input logic [7:0] opt,
                             input logic [7:0] sub, input logic [7:0] data[$]);
        int blen;
        blen = 2 + data.size();
        body.push_back(opt); body.push_back(sub);
        body.push_back(blen[15:8]); body.push_back(blen[7:0]);
        body.push_back(8'h00); body.push_back(8'h00);   // block info
        foreach (data[i]) body.push_back(data[i]);
        if (blen % 2) body.push_back(8'h00);
    endtask

    // queue a frame; data length taken from the body unless forced
    task automatic queue_frame(logic [47:0] mac, logic [15:0] fid, logic [7:0] sid,
                               logic [7:0] styp, logic [31:0] xid, logic [7:0] body[$],
                               int dlen, int trunc_to, bit implied_start);
        logic [7:0] f[$];
        t_in_beat   it;
        if (dlen < 0) dlen = body.size();
        f = {fid[15:8], fid[7:0], sid, styp, xid[31:24], xid[23:16], xid[15:8], xid[7:0],
             8'h00, 8'h00, dlen[15:8], dlen[7:0]};
        foreach (body[i]) f.push_back(body[i]);
        if (trunc_to > 0 && trunc_to < f.size()) f = f[0:trunc_to - 1];
        foreach (f[i]) begin
            it.data_byte  = f[i];
            it.source_mac = (i == 0) ? mac : 48'($urandom()) << 16 | 48'($urandom());
            it.first_byte = (i == 0) && !implied_start;
            it.last_byte  = (i == f.size() - 1);
            pending_bytes.push_back(it);
        end
    endtask

    function automatic logic [7:0] rand_byte();
        return 8'($urandom());
    endfunction

    // a response with random content and block order; some have header, length or xid faults
    task automatic queue_random_response(logic [31:0] xid);
        logic [7:0] body[$];
        logic [7:0] d[$];
        int nblk, nlen, mode;
        logic [47:0] mac;
        body = {};
        nblk = $urandom_range(0, 3);
        for (int b = 0; b < nblk; b++) begin
            d = {};
            case ($urandom_range(0, 4))
                0: begin
                    nlen = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 36)
                                                       : $urandom_range(0, 8);
                    repeat (nlen) d.push_back(rand_byte());
                    add_block(body, OPT_DEVPROP, SUB_NAME, d);
                end
                1: begin
                    repeat ($urandom_range(3, 5)) d.push_back(rand_byte());
                    add_block(body, OPT_DEVPROP, SUB_DEVID, d);
                end
                2: begin
                    repeat ($urandom_range(3, 13)) d.push_back(rand_byte());
                    add_block(body, OPT_IP, SUB_IP_PARAM, d);
                end
                3: begin
                    repeat ($urandom_range(0, 5)) d.push_back(rand_byte());
                    add_block(body, rand_byte(), rand_byte(), d);
                end
                default: begin
                    // zero length or one byte block header
                    body = {body, rand_byte(), rand_byte(), 8'h00, 8'($urandom_range(0, 1))};
                end
            endcase
        end
        mac = ($urandom_range(0, 2) == 0) ? mac_pool[$urandom_range(0, 7)]
                                          : {16'($urandom()), 32'($urandom())};
        mode = $urandom_range(0, 19);
        if (mode == 0)
            queue_frame(mac, 16'($urandom()), 8'($urandom()), 8'($urandom()), 32'($urandom()),
                        body, -1, 0, 0);
        else if (mode == 1)
            queue_frame(mac, FRAME_ID_IDENT, SVC_IDENTIFY, SVC_TYPE_OK, xid, body, -1,
                        $urandom_range(1, 14), 0);
        else if (mode == 2)
            queue_frame(mac, FRAME_ID_IDENT, SVC_IDENTIFY, SVC_TYPE_OK, xid, body,
                        $urandom_range(0, 40), 0, 0);
        else if (mode == 3)
            queue_frame(mac, FRAME_ID_IDENT, SVC_IDENTIFY, SVC_TYPE_OK, 32'($urandom()), body,
                        -1, 0, 0);
        else
            queue_frame(mac, FRAME_ID_IDENT, SVC_IDENTIFY, SVC_TYPE_OK, xid, body, -1, 0,
                        mode == 4);
    endtask

    task automatic wait_drained();
        while (pending_bytes.size() > 0 || i_valid || expected_beats.size() > 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic idx, logic [31:0] val);
        i_cfg_valid <= 1'b1; i_cfg_index <= idx; i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        // predictor follows the register write
        if (idx == CFG_EXPECTED_XID) begin
            xid_reg = val; seen_count = 0;
        end else begin
            limit_reg = val[4:0];
        end
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        logic [7:0] body[$];
        logic [7:0] d[$];
        logic [31:0] xid;
        xid_reg = 32'd1; limit_reg = 5'd16; seen_count = 0;
        foreach (nwork[i]) begin
            nwork[i] = '0; nkept[i] = '0;
        end
        clear_frame();
        for (int i = 0; i < 8; i++) mac_pool[i] = {16'($urandom()), 32'($urandom())};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: all options, header faults, short frames, extreme fields
        body = {};
        d = {"p", "l", "c", "-", "1"};
        add_block(body, OPT_DEVPROP, SUB_NAME, d);
        d = {8'hFF, 8'hFF, 8'h00, 8'h00};
        add_block(body, OPT_DEVPROP, SUB_DEVID, d);
        d = {8'd192, 8'd168, 8'd0, 8'd1, 8'hFF, 8'hFF, 8'hFF, 8'h0};
        add_block(body, OPT_IP, SUB_IP_PARAM, d);
        queue_frame(48'hFFFF_FFFF_FFFF, FRAME_ID_IDENT, SVC_IDENTIFY, SVC_TYPE_OK, 32'd1,
                    body, -1, 0, 0);
        queue_frame(48'hFFFF_FFFF_FFFF, FRAME_ID_IDENT, SVC_IDENTIFY, SVC_TYPE_OK, 32'd1,
                    body, -1, 0, 0);                          // duplicate
        queue_frame(48'h0, 16'h0102, SVC_IDENTIFY, SVC_TYPE_OK, 32'd1, body, -1, 0, 0);
        queue_frame(48'h1, FRAME_ID_IDENT, 8'h04, SVC_TYPE_OK, 32'd1, body, -1, 0, 0);
        queue_frame(48'h2, FRAME_ID_IDENT, SVC_IDENTIFY, SVC_TYPE_OK, 32'd2, body, -1, 0, 0);
        queue_frame(48'h3, 16'h0000, SVC_IDENTIFY, SVC_TYPE_OK, 32'd1, body, -1, 9, 0);
        // declared length cuts the ip block short: nothing partial committed
        queue_frame(48'h4, FRAME_ID_IDENT, SVC_IDENTIFY, SVC_TYPE_OK, 32'd1, body, 30, 0, 1);
        wait_drained();

        // long name gets truncated; all-ones xid
        write_cfg(CFG_EXPECTED_XID, 32'hFFFF_FFFF);
        write_cfg(CFG_DEVICE_LIMIT, 5'd1);
        body = {};
        d = {};
        repeat (40) d.push_back(rand_byte());
        add_block(body, OPT_DEVPROP, SUB_NAME, d);
        queue_frame(48'h5, FRAME_ID_IDENT, SVC_IDENTIFY, SVC_TYPE_OK, 32'hFFFF_FFFF, body,
                    -1, 0, 0);
        queue_frame(48'h6, FRAME_ID_IDENT, SVC_IDENTIFY, SVC_TYPE_OK, 32'hFFFF_FFFF, body,
                    -1, 0, 0);                                // table full
        wait_drained();
        write_cfg(CFG_DEVICE_LIMIT, 5'd0);
        queue_frame(48'h7, FRAME_ID_IDENT, SVC_IDENTIFY, SVC_TYPE_OK, 32'hFFFF_FFFF, body,
                    -1, 0, 0);
        wait_drained();
        write_cfg(CFG_DEVICE_LIMIT, 5'd31);

        // random phases, each with a new xid and limit
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 15 : (ph == 1) ? 85 : 0;
            recv_idle_pct = (ph == 0) ? 85 : (ph == 1) ? 15 : 0;
            xid = (ph == 2) ? 32'h0 : 32'($urandom());
            write_cfg(CFG_EXPECTED_XID, xid);
            write_cfg(CFG_DEVICE_LIMIT, (ph == 1) ? 5'd4 : 5'($urandom_range(5, 31)));
            for (int n = 0; n < 5; n++) queue_random_response(xid);
            if (ph == 2) begin
                // long receiver hold-off while the sender keeps offering bytes
                hold_recv = 1'b1;
                repeat (300) @(posedge i_clk);
                hold_recv = 1'b0;
            end
            for (int n = 0; n < 8; n++) queue_random_response(xid);
            wait_drained();
        end

        $display("frames sent %0d, accepted %0d, result beats checked %0d",
                 frames_sent, accepted_frames, beats_checked);
        if (errors == 0) begin
            $display("dcp_identify_response_filter_core test passed");
        end else begin
            $display("dcp_identify_response_filter_core test failed");
        end
        $finish;
    end

    // run limit
    initial begin
        #4ms;
        $display("dcp_identify_response_filter_core test failed");
        $finish;
    end

endmodule

// ===== files.f =====
src/dcp_pkg.sv
src/dcp_front.sv
src/dcp_back.sv
src/dcp_identify_response_filter_core.sv
src/dcp_checker.sv
test/tb_dcp_identify_response_filter_core.sv
